[hw/rtl/double_hash_table_defines.svh]
// Assertion macros used by the hash table top level.
`ifndef DOUBLE_HASH_TABLE_DEFINES_SVH
`define DOUBLE_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define DHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define DHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/dht_pkg.sv]
// Shared types, codes and helpers of the double hashing table.
`timescale 1ns / 1ps
package dht_pkg;

  localparam int DEF_SLOTS     = 128;
  localparam int DEF_KEY_BYTES = 8;

  localparam int KEY_W  = 64;
  localparam int ACT_W  = 2;
  localparam int OUT_W  = 2;
  localparam int SLOT_W = 7;
  localparam int CFG_W  = 8;
  localparam int MOD_W  = 8;
  localparam int KSUM_W = 11;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 8'd128;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic [OUT_W-1:0] OUT_OK   = 2'd0;
  localparam logic [OUT_W-1:0] OUT_FULL = 2'd1;
  localparam logic [OUT_W-1:0] OUT_MISS = 2'd2;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_USED  = 2'd1;
  localparam logic [1:0] ST_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] key;
  } slot_t;

  typedef struct packed {
    logic              start;
    logic [KSUM_W-1:0] k;
    logic [MOD_W-1:0]  m;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] rem_m;
    logic [MOD_W-1:0] rem_m1;
  } mod_rsp_t;

  typedef struct packed {
    logic  rd;
    logic  wr;
    slot_t wdata;
  } mem_ctl_t;

  function automatic logic [KSUM_W-1:0] key_sum(input logic [KEY_W-1:0] key);
    logic [KSUM_W-1:0] s;
    s = '0;
    for (int b = 0; b < KEY_W / 8; b++) begin
      s = s + KSUM_W'(key[8*b +: 8]);
    end
    return s;
  endfunction

endpackage

[hw/rtl/dht_mod.sv]
// Bit-serial unit that reduces the key byte sum modulo m and modulo m-1.
`timescale 1ns / 1ps
module dht_mod (
  input  logic              clk,
  input  logic              rst,
  input  dht_pkg::mod_req_t req,
  output dht_pkg::mod_rsp_t rsp
);
  import dht_pkg::*;

  logic [KSUM_W-1:0] kreg;
  logic [MOD_W-1:0]  d1;
  logic [MOD_W-1:0]  d2;
  logic [MOD_W-1:0]  r1;
  logic [MOD_W-1:0]  r2;
  logic [3:0]        left;
  logic              done;
  logic [MOD_W:0]    t1;
  logic [MOD_W:0]    t2;
  logic [MOD_W:0]    r1_next;
  logic [MOD_W:0]    r2_next;

  always_comb begin
    t1 = {r1, kreg[KSUM_W-1]};
    t2 = {r2, kreg[KSUM_W-1]};
    r1_next = (t1 >= {1'b0, d1}) ? (t1 - {1'b0, d1}) : t1;
    r2_next = (t2 >= {1'b0, d2}) ? (t2 - {1'b0, d2}) : t2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      done <= 1'b0;
    end else begin
      done <= (left == 4'd1);
      if (req.start) begin
        left <= 4'(KSUM_W);
      end else if (left != 4'd0) begin
        left <= left - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      kreg <= req.k;
      d1   <= req.m;
      d2   <= req.m - 8'd1;
      r1   <= '0;
      r2   <= '0;
    end else if (left != 4'd0) begin
      kreg <= kreg << 1;
      r1   <= r1_next[MOD_W-1:0];
      r2   <= r2_next[MOD_W-1:0];
    end
  end

  assign rsp.done   = done;
  assign rsp.rem_m  = r1;
  assign rsp.rem_m1 = r2;

endmodule

[hw/rtl/dht_store.sv]
// Slot memory holding status and key, with the clearing sweep after reset.
`timescale 1ns / 1ps
module dht_store #(
  parameter int SLOTS = dht_pkg::DEF_SLOTS,
  parameter int IDX_W = $clog2(SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  dht_pkg::mem_ctl_t ctl,
  input  logic [IDX_W-1:0]  addr,
  output dht_pkg::slot_t    rdata,
  output logic              busy
);
  import dht_pkg::*;

  slot_t            mem [SLOTS];
  logic [IDX_W-1:0] clr_addr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  slot_t            wdata;

  always_comb begin
    we    = busy || ctl.wr;
    waddr = busy ? clr_addr : addr;
    wdata = busy ? slot_t'{status: ST_EMPTY, key: '0} : ctl.wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == IDX_W'(SLOTS - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

[hw/rtl/double_hash_table.sv]
// Top level of the open-addressing hash table with double hashing.
// Requests arrive on the s_axis channel: the key in tdata, the action in tuser
// (insert, search or remove). Each request yields exactly one result beat on
// the m_axis channel: the slot index in tdata and the outcome in tuser.
// The table size register is written through the cfg channel; the user must
// write it only while idle, which the block itself does not enforce. It is
// clamped to the range 2 to min(SLOTS, 255) and sampled when a request is
// accepted. One request is processed at a time. After acceptance the key byte
// sum is reduced modulo m and m-1 by a bit-serial unit, then the slot memory is
// probed once per cycle, 1 to m probes in all. The result beat is presented
// once the output is free, and the next request can be taken in the cycle in
// which it is presented. An unused action code skips hashing and probing and
// yields a miss with slot zero. The modulo reduction and the probe loop through
// the registered memory read set the throughput. After reset the slot memory is
// swept to empty; s_axis_tready stays low during that sweep, while
// configuration writes are still taken. A finished result waits in the output
// register while the receiver stalls; the next request is accepted meanwhile
// but its result waits for the first to be taken.
`timescale 1ns / 1ps
`include "double_hash_table_defines.svh"
module double_hash_table #(
  parameter int SLOTS     = dht_pkg::DEF_SLOTS,
  parameter int KEY_BYTES = dht_pkg::DEF_KEY_BYTES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [dht_pkg::CFG_W-1:0]  cfg_data,       // table_size
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [dht_pkg::KEY_W-1:0]  s_axis_tdata,   // key_text
  input  logic [dht_pkg::ACT_W-1:0]  s_axis_tuser,   // action
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // slot_index, one zero bit
  output logic [dht_pkg::OUT_W-1:0]  m_axis_tuser    // outcome
);
  import dht_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int M_CAP = (SLOTS < 255) ? SLOTS : 255;
  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BYTES >= 8) ? {KEY_W{1'b1}} : ((KEY_W'(1) << (8 * KEY_BYTES)) - KEY_W'(1));

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HASH  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;

  logic [2:0]         state;
  logic [CFG_W-1:0]   table_size;
  logic [ACT_W-1:0]   act;
  logic [KEY_W-1:0]   key;
  logic [MOD_W-1:0]   m;
  logic [MOD_W-1:0]   step;
  logic [MOD_W-1:0]   j;
  logic [MOD_W-1:0]   probe_cnt;
  logic [OUT_W-1:0]   res_outcome;
  logic [SLOT_W-1:0]  res_slot;
  logic [SLOT_W-1:0]  out_slot;
  logic [OUT_W-1:0]   out_outcome;

  logic               s_accept;
  logic               act_known;
  logic [KEY_W-1:0]   in_key;
  logic [MOD_W-1:0]   m_clamp;
  mod_req_t           mod_req;
  mod_rsp_t           mod_rsp;
  mem_ctl_t           mem_ctl;
  slot_t              rdata;
  logic               clr_busy;
  logic [IDX_W-1:0]   mem_addr;
  logic [IDX_W+7:0]   addr_wide;
  logic [SLOT_W+7:0]  slot_wide;
  logic [MOD_W:0]     j_sum;
  logic [MOD_W-1:0]   j_next;
  logic               last;
  logic               hit_ins;
  logic               hit_find;
  logic               stop_miss;
  logic               advance;
  logic [MOD_W-1:0]   addr_j;
  logic               out_free;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE) && !clr_busy;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign act_known     = (s_axis_tuser == ACT_INSERT) || (s_axis_tuser == ACT_SEARCH) ||
                         (s_axis_tuser == ACT_REMOVE);
  assign in_key        = s_axis_tdata & KEY_MASK;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    if (table_size < 8'd2) begin
      m_clamp = 8'd2;
    end else if (table_size > 8'(M_CAP)) begin
      m_clamp = 8'(M_CAP);
    end else begin
      m_clamp = table_size;
    end
  end

  always_comb begin
    mod_req.start = s_accept && act_known;
    mod_req.k     = key_sum(in_key);
    mod_req.m     = m_clamp;
  end

  dht_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  always_comb begin
    j_sum     = {1'b0, j} + {1'b0, step};
    j_next    = (j_sum >= {1'b0, m}) ? 8'(j_sum - {1'b0, m}) : j_sum[MOD_W-1:0];
    last      = (({1'b0, probe_cnt} + 9'd1) == {1'b0, m});
    hit_ins   = (act == ACT_INSERT) && (rdata.status != ST_USED);
    hit_find  = (act != ACT_INSERT) && (rdata.status == ST_USED) && (rdata.key == key);
    stop_miss = (act != ACT_INSERT) && (rdata.status == ST_EMPTY);
    advance   = (state == S_CHECK) && !hit_ins && !hit_find && !stop_miss && !last;
    addr_j    = (state == S_HASH) ? mod_rsp.rem_m : (advance ? j_next : j);
    addr_wide = {{IDX_W{1'b0}}, addr_j};
    mem_addr  = addr_wide[IDX_W-1:0];
    slot_wide = {{SLOT_W{1'b0}}, j};
  end

  always_comb begin
    mem_ctl.rd    = ((state == S_HASH) && mod_rsp.done) || advance;
    mem_ctl.wr    = (state == S_CHECK) &&
                    (hit_ins || (hit_find && (act == ACT_REMOVE)));
    mem_ctl.wdata = hit_ins ? slot_t'{status: ST_USED, key: key}
                            : slot_t'{status: ST_TOMB, key: '0};
  end

  dht_store #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .rdata (rdata),
    .busy  (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      table_size    <= TABLE_SIZE_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        table_size <= cfg_data;
      end
      if ((state == S_DONE) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            state <= act_known ? S_HASH : S_DONE;
          end
        end
        S_HASH: begin
          if (mod_rsp.done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!advance) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      act         <= s_axis_tuser;
      key         <= in_key;
      m           <= m_clamp;
      res_outcome <= OUT_MISS;
      res_slot    <= '0;
    end
    if ((state == S_HASH) && mod_rsp.done) begin
      j         <= mod_rsp.rem_m;
      step      <= mod_rsp.rem_m1 + 8'd1;
      probe_cnt <= '0;
    end
    if (advance) begin
      j         <= j_next;
      probe_cnt <= probe_cnt + 8'd1;
    end
    if ((state == S_CHECK) && !advance) begin
      if (hit_ins || hit_find) begin
        res_outcome <= OUT_OK;
        res_slot    <= slot_wide[SLOT_W-1:0];
      end else begin
        res_outcome <= (act == ACT_INSERT) ? OUT_FULL : OUT_MISS;
        res_slot    <= '0;
      end
    end
    if ((state == S_DONE) && out_free) begin
      out_outcome <= res_outcome;
      out_slot    <= res_slot;
    end
  end

  assign m_axis_tdata = {1'b0, out_slot};
  assign m_axis_tuser = out_outcome;

  `DHT_ASSERT_NOW(a_mod_done_in_hash, mod_rsp.done, state == S_HASH,
    "modulo unit finished outside the hash phase")
  `DHT_ASSERT_NOW(a_probe_in_range, state == S_CHECK, (j < m) && (probe_cnt < m),
    "probe index or probe count reached the table size")
  `DHT_ASSERT_NOW(a_no_access_while_clearing, clr_busy,
    !mem_ctl.rd && !mem_ctl.wr && (state == S_IDLE),
    "slot memory accessed during the clearing sweep")
  `DHT_ASSERT_NEXT(a_result_issued, (state == S_DONE) && out_free,
    m_axis_tvalid && (state == S_IDLE), "finished result not presented on the output")
  `DHT_ASSERT_NOW(a_slot_zero_on_miss, m_axis_tvalid && (m_axis_tuser != OUT_OK),
    m_axis_tdata == 8'd0, "slot index not zero on a failed request")

endmodule

[tb/tb_double_hash_table.sv]
// Self-checking testbench for the double hashing table: streamed requests against a predictor.
`timescale 1ns / 1ps
module tb_double_hash_table;
  import dht_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int PHASE_ITEMS = 102;
  localparam int TB_IDX_W    = $clog2(DEF_SLOTS);

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] key;
  } request_t;

  typedef struct packed {
    logic [OUT_W-1:0]  outcome;
    logic [SLOT_W-1:0] slot;
  } lookup_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [KEY_W-1:0]  s_axis_tdata = '0;   // key_text
  logic [ACT_W-1:0]  s_axis_tuser = '0;   // action
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;        // slot_index, one zero bit
  logic [OUT_W-1:0]  m_axis_tuser;        // outcome

  request_t          pending[$];
  lookup_t           awaiting[$];
  logic [1:0]        slot_state [0:DEF_SLOTS-1];
  logic [KEY_W-1:0]  slot_keys  [0:DEF_SLOTS-1];
  logic [CFG_W-1:0]  table_size_q;
  int                errors = 0;
  int                n_issued = 0;
  int                burst_cnt = 0;
  int                gap_cnt = 0;
  int                hold_cnt = 0;
  logic              hold_done = 1'b0;
  logic [31:0]       cyc = '0;
  logic [1:0]        rx_mode = '0;
  int                stuck = 0;

  double_hash_table dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic lookup_t hash_access(input logic [ACT_W-1:0] act,
                                          input logic [KEY_W-1:0] key);
    int unsigned m, k, j, stride, p;
    logic        hit;
    lookup_t     r;
    r.outcome = OUT_MISS;
    r.slot    = '0;
    hit       = 1'b0;
    m = 32'(table_size_q);
    if (m < 2) m = 2;
    if (m > DEF_SLOTS) m = DEF_SLOTS;
    k = 0;
    for (p = 0; p < 8; p++) k = k + 32'(key[8*p +: 8]);
    j      = k % m;
    stride = 1 + k % (m - 1);
    if (act == ACT_INSERT) begin
      r.outcome = OUT_FULL;
      for (p = 0; p < m && !hit; p++) begin
        if (slot_state[j[TB_IDX_W-1:0]] != ST_USED) begin
          slot_state[j[TB_IDX_W-1:0]] = ST_USED;
          slot_keys[j[TB_IDX_W-1:0]]  = key;
          r.outcome     = OUT_OK;
          r.slot        = SLOT_W'(j);
          hit           = 1'b1;
        end
        j = (j + stride) % m;
      end
    end else if (act == ACT_SEARCH || act == ACT_REMOVE) begin
      for (p = 0; p < m && !hit; p++) begin
        if (slot_state[j[TB_IDX_W-1:0]] == ST_EMPTY) begin
          hit = 1'b1;
        end else if (slot_state[j[TB_IDX_W-1:0]] == ST_USED &&
                     slot_keys[j[TB_IDX_W-1:0]] == key) begin
          r.outcome = OUT_OK;
          r.slot    = SLOT_W'(j);
          hit       = 1'b1;
          if (act == ACT_REMOVE) slot_state[j[TB_IDX_W-1:0]] = ST_TOMB;
        end
        j = (j + stride) % m;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, what);
  endtask

  task automatic push_item(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key);
    request_t q;
    q.act = act;
    q.key = key;
    pending.push_back(q);
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || awaiting.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_table_size(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input int count);
    logic [KEY_W-1:0] pool [0:19];
    logic [KEY_W-1:0] kv;
    logic [ACT_W-1:0] act;
    int               npool, i, w;
    npool = $urandom_range(3, 20);
    for (i = 0; i < npool; i++) begin
      if (i > 0 && $urandom_range(0, 2) == 0) begin
        pool[i] = {pool[i-1][55:0], pool[i-1][63:56]};
      end else begin
        kv = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) kv = kv & ~({KEY_W{1'b1}} << (8 * $urandom_range(1, 7)));
        pool[i] = kv;
      end
    end
    for (i = 0; i < count; i++) begin
      w = $urandom_range(0, 99);
      if (w < 40) act = ACT_INSERT;
      else if (w < 70) act = ACT_SEARCH;
      else if (w < 95) act = ACT_REMOVE;
      else act = ACT_UNUSED;
      if ($urandom_range(0, 9) == 0) kv = {$urandom, $urandom};
      else kv = pool[$urandom_range(0, npool - 1)];
      push_item(act, kv);
    end
  endtask

  always @(posedge clk) begin : driver
    request_t sent;
    lookup_t  r;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      slot_state   = '{default: ST_EMPTY};
      slot_keys    = '{default: '0};
      table_size_q = TABLE_SIZE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) table_size_q = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        sent = pending.pop_front();
        r = hash_access(sent.act, sent.key);
        awaiting.push_back(r);
        n_issued <= n_issued + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_cnt != 0) begin
          s_axis_tvalid <= 1'b0;
          gap_cnt <= gap_cnt - 1;
        end else if (pending.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending[0].key;
          s_axis_tuser  <= pending[0].act;
          if (burst_cnt <= 1) begin
            burst_cnt <= $urandom_range(1, 24);
            gap_cnt   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_cnt <= burst_cnt - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && n_issued >= 400) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    lookup_t want;
    logic    rdy;
    cyc <= cyc + 1;
    if (cyc[7:0] == 8'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0: rdy = 1'b1;
      2'd1: rdy = 1'($urandom_range(0, 1));
      2'd2: rdy = ($urandom_range(0, 3) == 0);
      default: rdy = cyc[2];
    endcase
    m_axis_tready <= rdy && (hold_cnt == 0);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaiting.size() == 0) begin
        report_mismatch($sformatf("unexpected result: outcome %0d slot %0d",
                                  m_axis_tuser, m_axis_tdata));
      end else begin
        want = awaiting.pop_front();
        if (m_axis_tuser !== want.outcome || m_axis_tdata !== {1'b0, want.slot}) begin
          report_mismatch($sformatf("expected outcome %0d slot %0d, got outcome %0d tdata %0d",
                                    want.outcome, want.slot, m_axis_tuser, m_axis_tdata));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : main
    logic [CFG_W-1:0] sizes [0:11];
    int               i;
    sizes = '{8'd2, 8'd128, 8'd3, 8'd0, 8'd255, 8'd1, 8'd129, 8'd7, 8'd16, 8'd64, 8'd127,
              8'd0};
    sizes[11] = CFG_W'($urandom_range(0, 255));

    // Zero and all-ones keys, two keys with equal byte sums that collide, an unused action and an absent key.
    push_item(ACT_INSERT, 64'h0);
    push_item(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(ACT_SEARCH, 64'h0);
    push_item(ACT_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(ACT_INSERT, 64'h0102_0304_0506_0708);
    push_item(ACT_INSERT, 64'h0807_0605_0403_0201);
    push_item(ACT_SEARCH, 64'h0807_0605_0403_0201);
    push_item(ACT_REMOVE, 64'h0102_0304_0506_0708);
    push_item(ACT_SEARCH, 64'h0807_0605_0403_0201);
    push_item(ACT_INSERT, 64'h0807_0605_0403_0201);
    push_item(ACT_REMOVE, 64'h0807_0605_0403_0201);
    push_item(ACT_REMOVE, 64'h0102_0304_0506_0708);
    push_item(ACT_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(ACT_SEARCH, 64'h0000_0000_00C0_FFEE);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    // Smallest table: fill it, overflow it, then reuse a tombstone.
    set_table_size(8'd2);
    push_item(ACT_INSERT, 64'h11);
    push_item(ACT_INSERT, 64'h2222);
    push_item(ACT_INSERT, 64'h33);
    push_item(ACT_SEARCH, 64'h33);
    push_item(ACT_REMOVE, 64'h11);
    push_item(ACT_INSERT, 64'h33);
    push_item(ACT_UNUSED, 64'h0);
    wait_idle();

    for (i = 0; i < 12; i++) begin
      set_table_size(sizes[i]);
      run_random_phase(PHASE_ITEMS);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
